// ----- design/iss_pkg.sv -----
// Package for the indexed sequence store: request codes, status codes,
// sequencer types and fixed field widths. No dependencies.
package iss_pkg;

  localparam int DATA_W = 64;
  localparam int FUNC_W = 4;
  localparam int POS_W  = 9;
  localparam int CNT_W  = 9;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 4'd0,
    FN_PUSH_BACK  = 4'd1,
    FN_POP_FRONT  = 4'd2,
    FN_POP_BACK   = 4'd3,
    FN_INSERT     = 4'd4,
    FN_ERASE      = 4'd5,
    FN_READ_AT    = 4'd6,
    FN_CLEAR      = 4'd7,
    FN_FRONT      = 4'd8,
    FN_BACK       = 4'd9
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOVE = 3'b010,
    S_READ = 3'b100
  } state_e;

  // kind of memory walk run in S_MOVE
  typedef enum logic [1:0] {
    MV_OPEN  = 2'd0,
    MV_CLOSE = 2'd1,
    MV_ERASE = 2'd2
  } mode_e;

endpackage

// ----- design/indexed_sequence_store.sv -----
// Channel   Signals                               Handshake
// request   func_i, position_i, value_i           taken when start_i && !busy_o
// result    data_o, count_o, status_o             done_o, one cycle, no stall
//
// Pop back, clear, rejected requests and unused codes: result in the cycle after start.
// Read at, front, back: result after S_READ; a walk with nothing to move ends in S_MOVE.
// Push/insert move the entries from p up; pop front and erase move entries down.
// The walk streams one entry per cycle through the RAM's single read port.
// Reset clears the count; entry contents stay undefined until written.
// Results cannot be held off; a new request waits only on busy_o.
// Uses iss_pkg and iss_ram.
module indexed_sequence_store #(
  parameter int CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  func_i,
  input  logic [8:0]  position_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [63:0] data_o,
  output logic [8:0]  count_o,
  output logic [1:0]  status_o
);

  localparam int DATA_W = iss_pkg::DATA_W;
  localparam int CNT_W  = iss_pkg::CNT_W;
  localparam int AW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int XW     = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;

  iss_pkg::state_e  state_q, state_d;
  iss_pkg::mode_e   mode_q, mode_d;
  iss_pkg::status_e status_q, status_d;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rd_q, rd_d;
  logic [CW-1:0]     left_q, left_d;
  logic [CW-1:0]     wr_q, wr_d;
  logic [AW-1:0]     ins_q, ins_d;
  logic              pend_q, pend_d;
  logic              done_q, done_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] data_q, data_d;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  logic [XW-1:0] pos_x, cnt_x, place_x;

  iss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign pos_x = XW'(position_i);
  assign cnt_x = XW'(cnt_q);

  always_comb begin
    unique case (iss_pkg::func_e'(func_i))
      iss_pkg::FN_PUSH_FRONT: place_x = '0;
      iss_pkg::FN_PUSH_BACK:  place_x = cnt_x;
      default:                place_x = pos_x;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    rd_d     = rd_q;
    left_d   = left_q;
    wr_d     = wr_q;
    ins_d    = ins_q;
    val_d    = val_q;
    data_d   = data_q;
    pend_d   = 1'b0;
    done_d   = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    re       = 1'b0;
    raddr    = '0;

    unique case (state_q)
      iss_pkg::S_IDLE: begin
        if (start_i) begin
          val_d    = value_i;
          data_d   = '0;
          status_d = iss_pkg::ST_OK;
          unique case (iss_pkg::func_e'(func_i))
            iss_pkg::FN_PUSH_FRONT, iss_pkg::FN_PUSH_BACK, iss_pkg::FN_INSERT: begin
              // index check ranks ahead of the full check
              if (place_x > cnt_x) begin
                status_d = iss_pkg::ST_BAD_INDEX;
              end else if (cnt_q >= CW'(CAPACITY)) begin
                status_d = iss_pkg::ST_FULL;
              end else begin
                mode_d  = iss_pkg::MV_OPEN;
                rd_d    = cnt_q - 1'b1;
                left_d  = cnt_q - CW'(place_x);
                wr_d    = cnt_q;
                ins_d   = AW'(place_x);
                state_d = iss_pkg::S_MOVE;
              end
            end
            iss_pkg::FN_POP_FRONT: begin
              if (cnt_q == '0) begin
                status_d = iss_pkg::ST_EMPTY;
              end else begin
                mode_d  = iss_pkg::MV_CLOSE;
                rd_d    = CW'(1);
                left_d  = cnt_q - 1'b1;
                wr_d    = '0;
                state_d = iss_pkg::S_MOVE;
              end
            end
            iss_pkg::FN_POP_BACK: begin
              if (cnt_q == '0) begin
                status_d = iss_pkg::ST_EMPTY;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            iss_pkg::FN_ERASE: begin
              mode_d  = iss_pkg::MV_ERASE;
              rd_d    = '0;
              left_d  = cnt_q;
              wr_d    = '0;
              state_d = iss_pkg::S_MOVE;
            end
            iss_pkg::FN_READ_AT: begin
              if (pos_x < cnt_x) begin
                re      = 1'b1;
                raddr   = AW'(pos_x);
                state_d = iss_pkg::S_READ;
              end else begin
                status_d = iss_pkg::ST_BAD_INDEX;
              end
            end
            iss_pkg::FN_CLEAR: begin
              cnt_d = '0;
            end
            iss_pkg::FN_FRONT: begin
              if (cnt_q == '0) begin
                status_d = iss_pkg::ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = '0;
                state_d = iss_pkg::S_READ;
              end
            end
            iss_pkg::FN_BACK: begin
              if (cnt_q == '0) begin
                status_d = iss_pkg::ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = AW'(cnt_q - 1'b1);
                state_d = iss_pkg::S_READ;
              end
            end
            default: ;
          endcase
          done_d = (state_d == iss_pkg::S_IDLE);
        end
      end

      iss_pkg::S_MOVE: begin
        // Walk direction keeps the read ahead of the write, so a read never
        // hits the entry written in the same cycle.
        if (left_q != '0) begin
          re     = 1'b1;
          raddr  = rd_q[AW-1:0];
          left_d = left_q - 1'b1;
          pend_d = 1'b1;
          rd_d   = (mode_q == iss_pkg::MV_OPEN) ? rd_q - 1'b1 : rd_q + 1'b1;
        end
        if (pend_q) begin
          if (mode_q != iss_pkg::MV_ERASE || rdata != val_q) begin
            we    = 1'b1;
            waddr = wr_q[AW-1:0];
            wdata = rdata;
            wr_d  = (mode_q == iss_pkg::MV_OPEN) ? wr_q - 1'b1 : wr_q + 1'b1;
          end
        end
        if (left_q == '0 && !pend_q) begin
          unique case (mode_q)
            iss_pkg::MV_OPEN: begin
              we    = 1'b1;
              waddr = ins_q;
              wdata = val_q;
              cnt_d = cnt_q + 1'b1;
            end
            iss_pkg::MV_CLOSE: cnt_d = cnt_q - 1'b1;
            iss_pkg::MV_ERASE: cnt_d = wr_q;
            default: ;
          endcase
          state_d = iss_pkg::S_IDLE;
          done_d  = 1'b1;
        end
      end

      iss_pkg::S_READ: begin
        data_d  = rdata;
        done_d  = 1'b1;
        state_d = iss_pkg::S_IDLE;
      end

      default: state_d = iss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iss_pkg::S_IDLE;
      cnt_q   <= '0;
      left_q  <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    wr_q     <= wr_d;
    ins_q    <= ins_d;
    val_q    <= val_d;
    data_q   <= data_d;
  end

  assign busy_o   = (state_q != iss_pkg::S_IDLE);
  assign done_o   = done_q;
  assign data_o   = data_q;
  assign count_o  = CNT_W'(cnt_q);
  assign status_o = status_q;

endmodule

// ----- design/iss_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies. Contents are undefined until written.
module iss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/iss_checker.sv -----
// Port-level checks for indexed_sequence_store, attached by bind.
// Uses iss_pkg for request and status codes.
module iss_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [3:0]  func_i,
  input logic [8:0]  position_i,
  input logic [63:0] value_i,
  input logic        done_o,
  input logic [63:0] data_o,
  input logic [8:0]  count_o,
  input logic [1:0]  status_o
);

  logic req;
  assign req = start_i && !busy_o;

  // clear completes at once and empties the store
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req && func_i == iss_pkg::FN_CLEAR |=>
      done_o && count_o == '0 && status_o == iss_pkg::ST_OK)
    else $error("clear did not report an empty store");

  // a failed request never returns data
  a_err_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != iss_pkg::ST_OK |-> data_o == '0)
    else $error("nonzero data with error status");

  // every multi-cycle request ends with its result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // an in-range read at is busy without a result, then ends with done and busy low
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req && func_i == iss_pkg::FN_READ_AT && position_i < count_o |=>
      busy_o && !done_o ##1 done_o && !busy_o)
    else $error("read at latency wrong");

endmodule

bind indexed_sequence_store iss_port_checks u_iss_port_checks (.*);
